FILE: hw/rtl/sha1_message_digest_defines.svh
// Assertion macros for the checker file of the SHA-1 digest block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sha1_pkg.sv
package sha1_pkg;

    // Sizes of the algorithm.
    localparam int DEFAULT_LENGTH_BITS = 61;
    localparam int DIGEST_WORDS        = 5;
    localparam int BLOCK_BITS          = 512;
    localparam int ROUNDS              = 80;
    localparam int ROUND_BITS          = $clog2(ROUNDS);
    localparam int POS_BITS            = 6;

    // Initial chaining values.
    localparam logic [31:0] IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // Padding marker byte and the fill position where the length field starts.
    localparam logic [7:0]          PAD_BYTE  = 8'h80;
    localparam logic [POS_BITS-1:0] LEN_START = 6'd56;
    localparam logic [POS_BITS-1:0] POS_LAST  = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_DONE
    } state_t;

    // Where the controller goes once a block has been folded into the chaining words.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_MARK,
        RET_ZERO,
        RET_DONE
    } ret_t;

    // Source of a byte shifted into the block register.
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LENGTH
    } src_t;

    typedef struct packed {
        logic shift;
        src_t src;
        logic count_inc;
        logic start;
        logic round;
        logic add;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_pad;
        logic round_last;
    } sts_t;

endpackage

FILE: hw/rtl/sha1_ctrl.sv
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic byte_present,
    input  logic end_of_message,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    ret_t   ret_reg;
    ret_t   ret_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State, return point and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.shift     = 1'b1;
                        cmd.src       = SRC_DATA;
                        cmd.count_inc = 1'b1;
                        if (sts.pos_last)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_ROUND;
                            ret_next   = end_of_message ? RET_MARK : RET_IDLE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = ST_PAD_MARK;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end

            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                cmd.add = 1'b1;
                case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_MARK: state_next = ST_PAD_MARK;
                    RET_ZERO: state_next = ST_PAD_ZERO;
                    RET_DONE: state_next = ST_DONE;
                    default:  state_next = ST_IDLE;
                endcase
            end

            ST_PAD_MARK:
            begin
                cmd.shift = 1'b1;
                cmd.src   = SRC_MARK;
                if (sts.pos_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ROUND;
                    ret_next   = RET_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end

            ST_PAD_ZERO:
            begin
                if (sts.pos_pad)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    cmd.src   = SRC_ZERO;
                    if (sts.pos_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_ROUND;
                        ret_next   = RET_ZERO;
                    end
                end
            end

            ST_PAD_LEN:
            begin
                cmd.shift = 1'b1;
                cmd.src   = SRC_LENGTH;
                if (sts.pos_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ROUND;
                    ret_next   = RET_DONE;
                end
            end

            ST_DONE:
            begin
                // Wait until the output register is free, then hand over the digest.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/sha1_datapath.sv
module sha1_datapath
    import sha1_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = DEFAULT_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [7:0]  data_byte,
    output logic [31:0] digest_word_0,
    output logic [31:0] digest_word_1,
    output logic [31:0] digest_word_2,
    output logic [31:0] digest_word_3,
    output logic [31:0] digest_word_4
);

    logic [BLOCK_BITS-1:0]          win_reg;
    logic [POS_BITS-1:0]            pos_reg;
    logic [LENGTH_COUNTER_BITS-1:0] count_reg;
    logic [ROUND_BITS-1:0]          rnd_reg;
    logic [31:0]                    h_reg      [DIGEST_WORDS];
    logic [31:0]                    work_reg   [DIGEST_WORDS];
    logic [31:0]                    digest_reg [DIGEST_WORDS];

    logic [63:0] count_ext;
    logic [63:0] bit_len;
    logic [2:0]  len_idx;
    logic [7:0]  byte_in;
    logic [31:0] w0;
    logic [31:0] sched_x;
    logic [31:0] w_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    // Bit length of the message, eight times the byte count.
    assign count_ext = 64'(count_reg);
    assign bit_len   = {count_ext[60:0], 3'b000};
    assign len_idx   = 3'd7 - pos_reg[2:0];

    // Byte fed into the block register.
    always_comb
    begin
        case (cmd.src)
            SRC_DATA:   byte_in = data_byte;
            SRC_MARK:   byte_in = PAD_BYTE;
            SRC_ZERO:   byte_in = 8'h00;
            SRC_LENGTH: byte_in = bit_len[{len_idx, 3'b000} +: 8];
            default:    byte_in = 8'h00;
        endcase
    end

    // The block register doubles as the rolling schedule: word zero sits at the top.
    assign w0      = win_reg[511:480];
    assign sched_x = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ w0;
    assign w_new   = {sched_x[30:0], sched_x[31]};

    // Round function and constant for the current group of twenty rounds.
    always_comb
    begin
        if (rnd_reg < ROUND_BITS'(20))
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = K_0;
        end
        else if (rnd_reg < ROUND_BITS'(40))
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_1;
        end
        else if (rnd_reg < ROUND_BITS'(60))
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = K_2;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_3;
        end
    end

    assign t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] + k_val + w0;

    // Fill position, byte count, round counter and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            rnd_reg   <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= IV[i];
            end
        end
        else
        begin
            if (cmd.shift)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.start)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.round)
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                if (cmd.finish)
                begin
                    h_reg[i] <= IV[i];
                end
                else if (cmd.add)
                begin
                    h_reg[i] <= h_reg[i] + work_reg[i];
                end
            end
        end
    end

    // Block register, working words and digest output register.
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            win_reg <= {win_reg[BLOCK_BITS-9:0], byte_in};
        end
        else if (cmd.round)
        begin
            win_reg <= {win_reg[BLOCK_BITS-33:0], w_new};
        end

        if (cmd.start)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                work_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[4] <= work_reg[3];
            work_reg[3] <= work_reg[2];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t_val;
        end

        if (cmd.finish)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                digest_reg[i] <= h_reg[i];
            end
        end
    end

    // Status back to the controller.
    assign sts.pos_last   = (pos_reg == POS_LAST);
    assign sts.pos_pad    = (pos_reg == LEN_START);
    assign sts.round_last = (rnd_reg == ROUND_BITS'(ROUNDS - 1));

    assign digest_word_0 = digest_reg[0];
    assign digest_word_1 = digest_reg[1];
    assign digest_word_2 = digest_reg[2];
    assign digest_word_3 = digest_reg[3];
    assign digest_word_4 = digest_reg[4];

endmodule

FILE: hw/rtl/sha1_message_digest.sv
// SHA-1 digest engine that takes a message one byte per transfer and returns the
// 160-bit digest as five big-endian words in one output transfer after the item
// marked end_of_message; an end item without a byte closes the message as it stands.
// Every 64th byte starts the compression of the block, which runs one round per cycle
// through a single round unit and then adds the result into the chaining words; the
// input is stalled meanwhile, since the 512-bit block register also serves as the
// rolling message schedule. The end item adds the padding byte by byte up to the
// block end and may need a second block. A finished digest waits in an output
// register while the next message is already accepted.
module sha1_message_digest
    import sha1_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = DEFAULT_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word_0,
    output logic [31:0] digest_word_1,
    output logic [31:0] digest_word_2,
    output logic [31:0] digest_word_3,
    output logic [31:0] digest_word_4
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer for buffering, padding and compression.
    sha1_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sts            (sts),
        .cmd            (cmd)
    );

    // Block register, round unit and chaining words.
    sha1_datapath #(
        .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (data_byte),
        .digest_word_0 (digest_word_0),
        .digest_word_1 (digest_word_1),
        .digest_word_2 (digest_word_2),
        .digest_word_3 (digest_word_3),
        .digest_word_4 (digest_word_4)
    );

endmodule

FILE: hw/rtl/sha1_checker.sv
`include "sha1_message_digest_defines.svh"

module sha1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        byte_present,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word_0,
    input logic [31:0] digest_word_1,
    input logic [31:0] digest_word_2,
    input logic [31:0] digest_word_3,
    input logic [31:0] digest_word_4
);

    logic         in_xfer;
    logic [159:0] digest_all;

    // Accepted input transfer, and the digest words as one vector.
    assign in_xfer    = in_valid && !in_stall;
    assign digest_all = {digest_word_0, digest_word_1, digest_word_2,
                         digest_word_3, digest_word_4};

    // A stalled digest stays on the port unchanged.
    `SHA1_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(digest_all), "stalled digest changed")

    // After an end transfer the block is busy padding and compressing.
    `SHA1_ASSERT_NEXT(a_end_busy, in_xfer && end_of_message, in_stall, "input open after end")

    // An item with neither byte nor end leaves the input open.
    `SHA1_ASSERT_NEXT(a_idle_item, in_xfer && !byte_present && !end_of_message, !in_stall, "idle item stalled")

    // A new digest appears only after a stretch of internal work.
    `SHA1_ASSERT_NOW(a_digest_after_work, $rose(out_valid), $past(in_stall), "digest while input open")

endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (.*);
